/* rtl/core/lfcd_pkg.sv */
// shared constants and types for the fetch cache directory
package lfcd_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_WIDTH = 32;
   localparam int AGE_W     = 32;
   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int SLOT_W    = AGE_W + KEY_WIDTH;

   typedef enum logic [1:0] {
      SLOT_EMPTY   = 2'd0,
      SLOT_PENDING = 2'd1,
      SLOT_READY   = 2'd2
   } slot_state_type;

   localparam logic OP_LOOKUP = 1'b0;
   localparam logic OP_FILL   = 1'b1;

   localparam logic [2:0] RSP_HIT     = 3'd0;
   localparam logic [2:0] RSP_FETCH   = 3'd1;
   localparam logic [2:0] RSP_LOADED  = 3'd2;
   localparam logic [2:0] RSP_FAILED  = 3'd3;
   localparam logic [2:0] RSP_BUSY    = 3'd4;
   localparam logic [2:0] RSP_FULL    = 3'd5;
   localparam logic [2:0] RSP_FILLED  = 3'd6;
   localparam logic [2:0] RSP_IGNORED = 3'd7;

endpackage

/* rtl/core/lfcd_ram.sv */
// generic single-port-write ram with registered read
module lfcd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/lru_fetch_cache_directory.sv */
// Fully associative fetch cache directory with lru replacement and pending fills.
//
// A request on the req_ channel is either a lookup of req_key or a fill
// completion for req_key. Each request gives exactly one response on the
// rsp_ channel: a status, the slot index and the fetch request flag.
// Keys and age stamps live in one ram with a registered read; the
// slot states sit in flops next to it. A request reads all slots in turn
// (ENTRIES reads, the last data arriving in the cycle after its read), then the
// decide state writes the chosen slot back and loads the response register.
// The single ram read port walks every slot for each request; the next
// request is taken only once the decide state has loaded the response
// register, so a request has finished its scan and decide before the next is accepted.
// The response register holds its response until rsp_ready; meanwhile a new
// request may be accepted and scanned, and its decide cycle waits until the
// response register is free.
// Reset empties every slot and clears the use counter; key and age entries
// are only used from slots that are not empty, so the ram needs no clearing.
module lru_fetch_cache_directory (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_opcode,
   input  logic [31:0] req_key,
   input  logic        req_is_remote,
   input  logic        req_local_load_ok,
   input  logic        req_fill_ok,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [2:0]  rsp_status,
   output logic [3:0]  rsp_entry_index,
   output logic        rsp_fetch_request
);

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SCAN,
      FSM_DECIDE
   } fsm_type;

   fsm_type fsm_ff;

   lfcd_pkg::slot_state_type slot_state_ff [lfcd_pkg::ENTRIES];

   logic [lfcd_pkg::AGE_W-1:0]     use_counter_ff;
   logic [lfcd_pkg::CNT_W-1:0]     rd_cnt_ff;
   logic                           proc_valid_ff;
   logic [lfcd_pkg::IDX_W-1:0]     proc_idx_ff;

   // latched request
   logic                           op_ff;
   logic [lfcd_pkg::KEY_WIDTH-1:0] key_ff;
   logic                           remote_ff;
   logic                           load_ok_ff;
   logic                           fill_ok_ff;

   // scan trackers
   logic                           match_found_ff;
   logic                           match_ready_ff;
   logic [lfcd_pkg::IDX_W-1:0]     match_idx_ff;
   logic                           have_empty_ff;
   logic [lfcd_pkg::IDX_W-1:0]     empty_idx_ff;
   logic                           have_ready_ff;
   logic [lfcd_pkg::IDX_W-1:0]     old_idx_ff;
   logic [lfcd_pkg::AGE_W-1:0]     old_age_ff;

   logic                           rsp_valid_ff;
   logic [2:0]                     rsp_status_ff;
   logic [3:0]                     rsp_index_ff;
   logic                           rsp_fetch_ff;

   // ram interface
   logic                           rd_en;
   logic [lfcd_pkg::SLOT_W-1:0]    rd_data;
   logic [lfcd_pkg::KEY_WIDTH-1:0] rd_key;
   logic [lfcd_pkg::AGE_W-1:0]     rd_age;
   logic                           wr_en;

   lfcd_pkg::slot_state_type       proc_state;
   logic                           key_eq;
   logic                           rsp_free;
   logic                           decide_go;
   logic                           scan_last;

   // decide results
   logic [2:0]                     dec_status;
   logic [lfcd_pkg::IDX_W-1:0]     dec_idx;
   logic                           dec_fetch;
   logic                           dec_wr_ram;
   logic                           dec_wr_state;
   lfcd_pkg::slot_state_type       dec_state;
   logic                           dec_count;

   assign rd_en      = (fsm_ff == FSM_SCAN) &&
                       (rd_cnt_ff < lfcd_pkg::CNT_W'(lfcd_pkg::ENTRIES));
   assign rd_key     = rd_data[lfcd_pkg::KEY_WIDTH-1:0];
   assign rd_age     = rd_data[lfcd_pkg::KEY_WIDTH +: lfcd_pkg::AGE_W];
   assign proc_state = slot_state_ff[proc_idx_ff];
   assign key_eq     = (rd_key == key_ff);
   assign scan_last  = proc_valid_ff &&
                       (proc_idx_ff == lfcd_pkg::IDX_W'(lfcd_pkg::ENTRIES - 1));
   assign rsp_free   = !rsp_valid_ff || rsp_ready;
   assign decide_go  = (fsm_ff == FSM_DECIDE) && rsp_free;
   assign wr_en      = decide_go && dec_wr_ram;

   assign req_ready         = (fsm_ff == FSM_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_index   = rsp_index_ff;
   assign rsp_fetch_request = rsp_fetch_ff;

   lfcd_ram #(
      .WIDTH(lfcd_pkg::SLOT_W),
      .DEPTH(lfcd_pkg::ENTRIES)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (dec_idx),
      .wr_data ({use_counter_ff, key_ff}),
      .rd_en   (rd_en),
      .rd_addr (rd_cnt_ff[lfcd_pkg::IDX_W-1:0]),
      .rd_data (rd_data)
   );

   always_comb begin
      dec_status   = lfcd_pkg::RSP_IGNORED;
      dec_idx      = '0;
      dec_fetch    = 1'b0;
      dec_wr_ram   = 1'b0;
      dec_wr_state = 1'b0;
      dec_state    = lfcd_pkg::SLOT_EMPTY;
      dec_count    = 1'b0;
      if (op_ff == lfcd_pkg::OP_LOOKUP) begin
         if (match_found_ff) begin
            if (match_ready_ff) begin
               dec_status = lfcd_pkg::RSP_HIT;
               dec_idx    = match_idx_ff;
               dec_wr_ram = 1'b1;
               dec_count  = 1'b1;
            end else begin
               dec_status = lfcd_pkg::RSP_BUSY;
            end
         end else if (have_empty_ff || have_ready_ff) begin
            dec_idx      = have_empty_ff ? empty_idx_ff : old_idx_ff;
            dec_wr_ram   = 1'b1;
            dec_wr_state = 1'b1;
            dec_count    = 1'b1;
            if (remote_ff) begin
               dec_status = lfcd_pkg::RSP_FETCH;
               dec_fetch  = 1'b1;
               dec_state  = lfcd_pkg::SLOT_PENDING;
            end else if (load_ok_ff) begin
               dec_status = lfcd_pkg::RSP_LOADED;
               dec_state  = lfcd_pkg::SLOT_READY;
            end else begin
               // failed local load leaves the slot empty but keeps the stamp
               dec_status = lfcd_pkg::RSP_FAILED;
               dec_state  = lfcd_pkg::SLOT_EMPTY;
            end
         end else begin
            dec_status = lfcd_pkg::RSP_FULL;
         end
      end else if (fill_ok_ff && match_found_ff) begin
         dec_status   = lfcd_pkg::RSP_FILLED;
         dec_idx      = match_idx_ff;
         dec_wr_state = 1'b1;
         dec_state    = lfcd_pkg::SLOT_READY;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff         <= FSM_IDLE;
         use_counter_ff <= '0;
         rd_cnt_ff      <= '0;
         proc_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         for (int i = 0; i < lfcd_pkg::ENTRIES; i++) begin
            slot_state_ff[i] <= lfcd_pkg::SLOT_EMPTY;
         end
      end else begin
         proc_valid_ff <= rd_en;
         proc_idx_ff   <= rd_cnt_ff[lfcd_pkg::IDX_W-1:0];
         // a decide cycle reloads the register in the same edge
         if (rsp_valid_ff && rsp_ready && !decide_go) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (fsm_ff)
            FSM_IDLE: begin
               if (req_valid) begin
                  op_ff          <= req_opcode;
                  key_ff         <= lfcd_pkg::KEY_WIDTH'(req_key);
                  remote_ff      <= req_is_remote;
                  load_ok_ff     <= req_local_load_ok;
                  fill_ok_ff     <= req_fill_ok;
                  match_found_ff <= 1'b0;
                  have_empty_ff  <= 1'b0;
                  have_ready_ff  <= 1'b0;
                  rd_cnt_ff      <= '0;
                  fsm_ff         <= FSM_SCAN;
               end
            end
            FSM_SCAN: begin
               if (rd_en) begin
                  rd_cnt_ff <= rd_cnt_ff + 1'b1;
               end
               if (proc_valid_ff) begin
                  // first slot whose key matches; a fill only looks at pending slots
                  if (!match_found_ff && key_eq &&
                      (((op_ff == lfcd_pkg::OP_LOOKUP) &&
                        (proc_state != lfcd_pkg::SLOT_EMPTY)) ||
                       ((op_ff == lfcd_pkg::OP_FILL) &&
                        (proc_state == lfcd_pkg::SLOT_PENDING)))) begin
                     match_found_ff <= 1'b1;
                     match_idx_ff   <= proc_idx_ff;
                     match_ready_ff <= (proc_state == lfcd_pkg::SLOT_READY);
                  end
                  if (!have_empty_ff && (proc_state == lfcd_pkg::SLOT_EMPTY)) begin
                     have_empty_ff <= 1'b1;
                     empty_idx_ff  <= proc_idx_ff;
                  end
                  // strict compare keeps the lowest slot among equal stamps
                  if ((proc_state == lfcd_pkg::SLOT_READY) &&
                      (!have_ready_ff || (rd_age < old_age_ff))) begin
                     have_ready_ff <= 1'b1;
                     old_idx_ff    <= proc_idx_ff;
                     old_age_ff    <= rd_age;
                  end
               end
               if (scan_last) begin
                  fsm_ff <= FSM_DECIDE;
               end
            end
            FSM_DECIDE: begin
               if (rsp_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_status_ff <= dec_status;
                  rsp_index_ff  <= 4'(dec_idx);
                  rsp_fetch_ff  <= dec_fetch;
                  if (dec_wr_state) begin
                     slot_state_ff[dec_idx] <= dec_state;
                  end
                  if (dec_count) begin
                     use_counter_ff <= use_counter_ff + 1'b1;
                  end
                  fsm_ff <= FSM_IDLE;
               end
            end
            default: begin
               fsm_ff <= FSM_IDLE;
            end
         endcase
      end
   end

   // fetch request flag goes with the fetch status and nothing else
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_fetch_ff == (rsp_status_ff == lfcd_pkg::RSP_FETCH)))
      else $error("fetch request flag disagrees with status");

   // slot index is zero for busy, full and ignored responses
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ((rsp_status_ff == lfcd_pkg::RSP_BUSY) ||
                        (rsp_status_ff == lfcd_pkg::RSP_FULL) ||
                        (rsp_status_ff == lfcd_pkg::RSP_IGNORED)))
      |-> (rsp_index_ff == 4'd0))
      else $error("nonzero slot index on busy, full or ignored");

   // the use counter moves only in a decide cycle
   assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (use_counter_ff != $past(use_counter_ff)))
      |-> ($past(fsm_ff) == FSM_DECIDE))
      else $error("use counter changed outside decide");

   // a new response never overwrites one still waiting
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> $stable(rsp_status_ff))
      else $error("waiting response overwritten");

endmodule
